@@ sv/segment_visibility_against_facets_assert.svh @@
// Assertion macros for the segment visibility block checker.
// Expects clk and rst in the scope of each use.
`ifndef SEGMENT_VISIBILITY_AGAINST_FACETS_ASSERT_SVH
`define SEGMENT_VISIBILITY_AGAINST_FACETS_ASSERT_SVH

// same-cycle implication
`define SVAF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svaf: same-cycle property failed");

// next-cycle implication
`define SVAF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svaf: next-cycle property failed");

`endif

@@ sv/svaf_pkg.sv @@
// Package for the segment visibility block: widths, item structs, facet type,
// function and state codes. No dependencies.
package svaf_pkg;

  localparam int COORD_BITS          = 24;
  localparam int EXT_BITS            = COORD_BITS + 2;
  localparam int DIFF_BITS           = COORD_BITS + 3;
  localparam int PROD_BITS           = 2 * DIFF_BITS;
  localparam int CROSS_BITS          = PROD_BITS + 1;
  localparam int NUM_BITS            = COORD_BITS + 1;
  localparam int DIV_BY              = 400;
  localparam int DIV_BIAS            = 200;
  localparam int DIV_SHIFT           = NUM_BITS + $clog2(DIV_BY);
  localparam int RECIP_BITS          = NUM_BITS + 1;
  localparam int INDEX_BITS          = 6;
  localparam int TOTAL_BITS          = 7;
  localparam int MAX_FACETS_DEFAULT  = 64;

  // ceil(2^DIV_SHIFT / DIV_BY): exact floor division for any NUM_BITS operand
  localparam logic [RECIP_BITS-1:0] DIV_RECIP =
    RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'(DIV_BY) - 64'd1) / 64'(DIV_BY));

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EXT_BITS-1:0]   ext_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_APPEND = 2'd1,
    FN_QUERY  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_QUERY,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [1:0] func;
    coord_t     x_start;
    coord_t     y_start;
    coord_t     x_end;
    coord_t     y_end;
  } in_item_t;

  typedef struct packed {
    logic                  visible;
    logic [INDEX_BITS-1:0] blocking_index;
    logic                  status;
    logic [TOTAL_BITS-1:0] facet_total;
  } out_item_t;

  typedef struct packed {
    ext_t px;
    ext_t py;
    ext_t qx;
    ext_t qy;
  } facet_t;

  typedef struct packed {
    logic live;
    logic inrange;
    logic last;
  } pipe_tag_t;

endpackage

@@ sv/svaf_cell.sv @@
// One cell of the facet ring: holds one extended facet, loads on append,
// passes its facet to the previous cell on each shift. Uses svaf_pkg.
module svaf_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  logic            load_en,
  input  svaf_pkg::facet_t shift_in,
  input  svaf_pkg::facet_t load_data,
  output svaf_pkg::facet_t facet
);
  import svaf_pkg::*;

  always_ff @(posedge clk) begin
    if (load_en) begin
      facet <= load_data;
    end else if (shift_en) begin
      facet <= shift_in;
    end
  end

endmodule

@@ sv/svaf_cross.sv @@
// Pipelined crossing test of the query segment against one facet per cycle:
// differences, exact products, then signs of the five cross products. Uses svaf_pkg.
module svaf_cross (
  input  logic                clk,
  input  logic                rst,
  input  svaf_pkg::pipe_tag_t tag_in,
  input  svaf_pkg::in_item_t  query,
  input  svaf_pkg::facet_t    facet,
  output svaf_pkg::pipe_tag_t tag_out,
  output logic                hit
);
  import svaf_pkg::*;

  pipe_tag_t s1_tag;
  diff_t abx, aby, pqx, pqy, pax, pay, qax, qay, bpx, bpy, apx, apy;
  prod_t m0a, m0b, m1a, m1b, m2a, m2b, m3a, m3b, m4a, m4b;
  cross_t c0, c1, c2, c3, c4;
  logic neg;

  function automatic logic nonneg(input cross_t c);
    return !c[CROSS_BITS-1];
  endfunction

  function automatic logic nonpos(input cross_t c);
    return c[CROSS_BITS-1] || (c == '0);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag  <= '0;
      tag_out <= '0;
    end else begin
      s1_tag  <= tag_in;
      tag_out <= s1_tag;
    end
  end

  always_ff @(posedge clk) begin
    abx <= DIFF_BITS'(query.x_end) - DIFF_BITS'(query.x_start);
    aby <= DIFF_BITS'(query.y_end) - DIFF_BITS'(query.y_start);
    pqx <= DIFF_BITS'(facet.qx) - DIFF_BITS'(facet.px);
    pqy <= DIFF_BITS'(facet.qy) - DIFF_BITS'(facet.py);
    pax <= DIFF_BITS'(facet.px) - DIFF_BITS'(query.x_start);
    pay <= DIFF_BITS'(facet.py) - DIFF_BITS'(query.y_start);
    qax <= DIFF_BITS'(facet.qx) - DIFF_BITS'(query.x_start);
    qay <= DIFF_BITS'(facet.qy) - DIFF_BITS'(query.y_start);
    bpx <= DIFF_BITS'(query.x_end) - DIFF_BITS'(facet.px);
    bpy <= DIFF_BITS'(query.y_end) - DIFF_BITS'(facet.py);
    apx <= DIFF_BITS'(query.x_start) - DIFF_BITS'(facet.px);
    apy <= DIFF_BITS'(query.y_start) - DIFF_BITS'(facet.py);
  end

  always_ff @(posedge clk) begin
    m0a <= abx * pqy;
    m0b <= aby * pqx;
    m1a <= pax * aby;
    m1b <= pay * abx;
    m2a <= abx * qay;
    m2b <= aby * qax;
    m3a <= bpx * pqy;
    m3b <= bpy * pqx;
    m4a <= pqx * apy;
    m4b <= pqy * apx;
  end

  // negative orientation flips every later sign test
  always_comb begin
    c0  = CROSS_BITS'(m0a) - CROSS_BITS'(m0b);
    c1  = CROSS_BITS'(m1a) - CROSS_BITS'(m1b);
    c2  = CROSS_BITS'(m2a) - CROSS_BITS'(m2b);
    c3  = CROSS_BITS'(m3a) - CROSS_BITS'(m3b);
    c4  = CROSS_BITS'(m4a) - CROSS_BITS'(m4b);
    neg = c0[CROSS_BITS-1];
    if (neg) begin
      hit = nonpos(c1) && nonpos(c2) && nonpos(c3) && nonpos(c4);
    end else begin
      hit = nonneg(c1) && nonneg(c2) && nonneg(c3) && nonneg(c4);
    end
  end

endmodule

@@ sv/svaf_div400.sv @@
// Division by the extension constant for two lanes (x and y) by reciprocal
// multiply: operands latched, then one registered multiply. Uses svaf_pkg.
module svaf_div400 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [svaf_pkg::NUM_BITS-1:0] num_x,
  input  logic [svaf_pkg::NUM_BITS-1:0] num_y,
  output logic                          done,
  output logic [svaf_pkg::NUM_BITS-1:0] quot_x,
  output logic [svaf_pkg::NUM_BITS-1:0] quot_y
);
  import svaf_pkg::*;

  localparam int PROD_W = NUM_BITS + RECIP_BITS;

  logic                loaded;
  logic [NUM_BITS-1:0] nx, ny;
  logic [PROD_W-1:0]   prod_x, prod_y;

  assign prod_x = PROD_W'(nx) * PROD_W'(DIV_RECIP);
  assign prod_y = PROD_W'(ny) * PROD_W'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
      done   <= 1'b0;
    end else begin
      loaded <= start;
      done   <= loaded;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nx <= num_x;
      ny <= num_y;
    end
    if (loaded) begin
      quot_x <= NUM_BITS'(prod_x >> DIV_SHIFT);
      quot_y <= NUM_BITS'(prod_y >> DIV_SHIFT);
    end
  end

endmodule

@@ sv/segment_visibility_against_facets.sv @@
// Top level of the segment visibility block: facet ring, crossing test pipeline,
// extension divider and control. Uses svaf_pkg, svaf_cell, svaf_cross, svaf_div400.
//
// An item is taken when start is high and busy is low; its one result shows on
// result for a single cycle with done high and must be taken then. Clear and
// unused codes, and an append to a full table, answer in the next cycle. An
// append runs in steps: the divider latches its operands, the registered
// reciprocal multiply divides them by 400 for the endpoint push, and the
// extended facet is written into the ring.
// A query rotates the whole facet ring once, whatever the fill, past a single
// crossing test pipeline, one facet per cycle, and the answer is formed as the
// last facet's tag leaves that pipeline.
// The next item can be started in the cycle its predecessor's result shows.
module segment_visibility_against_facets #(
  parameter int MAX_FACETS = svaf_pkg::MAX_FACETS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  svaf_pkg::in_item_t  item,
  output logic                done,
  output svaf_pkg::out_item_t result
);
  import svaf_pkg::*;

  localparam int CNT_W   = $clog2(MAX_FACETS + 1);
  localparam int IDX_W   = (MAX_FACETS > 1) ? $clog2(MAX_FACETS) : 1;
  localparam int TOT_EXT = CNT_W + TOTAL_BITS;
  localparam int IDX_EXT = IDX_W + INDEX_BITS;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] step, step_next;
  logic [IDX_W-1:0] res_idx, res_idx_next;
  logic [IDX_W-1:0] found_idx, found_idx_next;
  logic             found, found_next;
  logic             done_next;
  out_item_t        result_next;
  in_item_t         held;

  logic             shift_en, load_en, div_start, div_done, hit;
  pipe_tag_t        tag_in, tag_out;
  facet_t           facet_new;
  facet_t           facet_q [MAX_FACETS];

  logic signed [NUM_BITS-1:0] dx, dy, hdx, hdy;
  logic [NUM_BITS-1:0]        num_x, num_y, quot_x, quot_y;
  ext_t                       qx_e, qy_e, ex, ey;

  function automatic logic [TOTAL_BITS-1:0] tot(input logic [CNT_W-1:0] c);
    logic [TOT_EXT-1:0] e;
    e = TOT_EXT'(c);
    return e[TOTAL_BITS-1:0];
  endfunction

  function automatic logic [INDEX_BITS-1:0] idx_out(input logic [IDX_W-1:0] i);
    logic [IDX_EXT-1:0] e;
    e = IDX_EXT'(i);
    return e[INDEX_BITS-1:0];
  endfunction

  assign busy = (state != ST_IDLE);

  // divider operand: |start - end| + half divisor, rounds ties away from zero
  always_comb begin
    dx    = NUM_BITS'(item.x_start) - NUM_BITS'(item.x_end);
    dy    = NUM_BITS'(item.y_start) - NUM_BITS'(item.y_end);
    num_x = NUM_BITS'(dx[NUM_BITS-1] ? -dx : dx) + NUM_BITS'(DIV_BIAS);
    num_y = NUM_BITS'(dy[NUM_BITS-1] ? -dy : dy) + NUM_BITS'(DIV_BIAS);
  end

  always_comb begin
    hdx          = NUM_BITS'(held.x_start) - NUM_BITS'(held.x_end);
    hdy          = NUM_BITS'(held.y_start) - NUM_BITS'(held.y_end);
    qx_e         = EXT_BITS'(quot_x);
    qy_e         = EXT_BITS'(quot_y);
    ex           = hdx[NUM_BITS-1] ? -qx_e : qx_e;
    ey           = hdy[NUM_BITS-1] ? -qy_e : qy_e;
    facet_new.px = EXT_BITS'(held.x_start) + ex;
    facet_new.py = EXT_BITS'(held.y_start) + ey;
    facet_new.qx = EXT_BITS'(held.x_end) - ex;
    facet_new.qy = EXT_BITS'(held.y_end) - ey;
  end

  svaf_div400 u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_x  (num_x),
    .num_y  (num_y),
    .done   (div_done),
    .quot_x (quot_x),
    .quot_y (quot_y)
  );

  for (genvar i = 0; i < MAX_FACETS; i++) begin : g_ring
    localparam int NXT = (i + 1) % MAX_FACETS;
    svaf_cell u_cell (
      .clk       (clk),
      .shift_en  (shift_en),
      .load_en   (load_en && (count == CNT_W'(i))),
      .shift_in  (facet_q[NXT]),
      .load_data (facet_new),
      .facet     (facet_q[i])
    );
  end

  svaf_cross u_cross (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (tag_in),
    .query   (held),
    .facet   (facet_q[0]),
    .tag_out (tag_out),
    .hit     (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      step      <= '0;
      res_idx   <= '0;
      found     <= 1'b0;
      found_idx <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      step      <= step_next;
      res_idx   <= res_idx_next;
      found     <= found_next;
      found_idx <= found_idx_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (start && !busy) begin
      held <= item;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    step_next      = step;
    res_idx_next   = res_idx;
    found_next     = found;
    found_idx_next = found_idx;
    done_next      = 1'b0;
    result_next    = result;
    div_start      = 1'b0;
    load_en        = 1'b0;
    shift_en       = 1'b0;
    tag_in         = '0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          result_next             = '0;
          result_next.facet_total = tot(count);
          unique case (item.func)
            FN_CLEAR: begin
              count_next              = '0;
              result_next.facet_total = tot('0);
              done_next               = 1'b1;
            end
            FN_APPEND: begin
              if (count >= CNT_W'(MAX_FACETS)) begin
                result_next.status = 1'b1;
                done_next          = 1'b1;
              end else begin
                div_start  = 1'b1;
                state_next = ST_DIV;
              end
            end
            FN_QUERY: begin
              step_next    = '0;
              res_idx_next = '0;
              found_next   = 1'b0;
              state_next   = ST_QUERY;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          load_en                 = 1'b1;
          count_next              = count + CNT_W'(1);
          result_next             = '0;
          result_next.facet_total = tot(count + CNT_W'(1));
          done_next               = 1'b1;
          state_next              = ST_IDLE;
        end
      end
      ST_QUERY: begin
        shift_en       = 1'b1;
        tag_in.live    = 1'b1;
        tag_in.inrange = (step < count);
        tag_in.last    = (step == CNT_W'(MAX_FACETS - 1));
        step_next      = step + CNT_W'(1);
        if (tag_in.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // test results leave the pipeline in facet order; first hit wins
    if (tag_out.live) begin
      res_idx_next = res_idx + IDX_W'(1);
      if (tag_out.inrange && hit && !found) begin
        found_next     = 1'b1;
        found_idx_next = res_idx;
      end
      if (tag_out.last) begin
        result_next                = '0;
        result_next.visible        = !found_next;
        result_next.blocking_index = found_next ? idx_out(found_idx_next) : '0;
        result_next.facet_total    = tot(count);
        done_next                  = 1'b1;
        state_next                 = ST_IDLE;
      end
    end
  end

endmodule

@@ sv/svaf_checker.sv @@
// Port-level checker for the segment visibility block, bound to the top level.
// Uses svaf_pkg types and the macros of segment_visibility_against_facets_assert.svh.
`include "segment_visibility_against_facets_assert.svh"

module svaf_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input svaf_pkg::out_item_t result
);

  `SVAF_ASSERT_IMP(a_done_cause, done, $past(start) || $past(busy))
  `SVAF_ASSERT_NXT(a_accept_progress, start && !busy, busy || done)
  `SVAF_ASSERT_IMP(a_busy_fall, !$past(rst) && $fell(busy), done)
  `SVAF_ASSERT_IMP(a_index_clear, done && (result.visible || result.status), result.blocking_index == 0)

endmodule

bind segment_visibility_against_facets svaf_checker u_svaf_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

@@ sim/tb_top.sv @@
// Testbench for segment_visibility_against_facets: directed and random clear, append
// and query items, checked item by item against an in-bench facet visibility predictor.
// Depends on svaf_pkg and the segment_visibility_against_facets RTL.
`timescale 1ns / 1ps

module tb_top;
  import svaf_pkg::*;

  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam coord_t     C_MAX     = coord_t'(24'h7FFFFF);
  localparam coord_t     C_MIN     = coord_t'(24'h800000);
  localparam int         ITEM_GOAL = 1650;

  class facet_scoreboard;
    facet_t    facets[MAX_FACETS_DEFAULT];
    int        facet_count;
    out_item_t pending_answers[$];
    int        error_count;

    function new();
      facet_count = 0;
      error_count = 0;
    endfunction

    static function longint push_div400(longint d);
      longint m;
      m = ((d < 0) ? -d : d);
      m = (m + DIV_BIAS) / DIV_BY;
      return (d < 0) ? -m : m;
    endfunction

    static function int cross_sign(longint x1, longint y1, longint x2, longint y2);
      longint c;
      c = x1 * y2 - y1 * x2;
      if (c < 0) return -1;
      if (c == 0) return 0;
      return 1;
    endfunction

    // zero cross products count as touching
    static function bit facet_blocks(longint ax, longint ay, longint bx, longint by,
                                     facet_t f);
      longint px, py, qx, qy, abx, aby, pqx, pqy;
      px = $signed(f.px);
      py = $signed(f.py);
      qx = $signed(f.qx);
      qy = $signed(f.qy);
      abx = bx - ax;
      aby = by - ay;
      pqx = qx - px;
      pqy = qy - py;
      if (cross_sign(abx, aby, pqx, pqy) < 0) begin
        abx = -abx;
        aby = -aby;
        pqx = -pqx;
        pqy = -pqy;
      end
      if (cross_sign(px - ax, py - ay, abx, aby) < 0) return 1'b0;
      if (cross_sign(abx, aby, qx - ax, qy - ay) < 0) return 1'b0;
      if (cross_sign(bx - px, by - py, pqx, pqy) < 0) return 1'b0;
      if (cross_sign(pqx, pqy, ax - px, ay - py) < 0) return 1'b0;
      return 1'b1;
    endfunction

    function void note_item(in_item_t it);
      out_item_t ans;
      facet_t    f;
      longint    xs, ys, xe, ye, ex, ey;
      ans = '0;
      xs = $signed(it.x_start);
      ys = $signed(it.y_start);
      xe = $signed(it.x_end);
      ye = $signed(it.y_end);
      case (it.func)
        FN_CLEAR: begin
          facet_count = 0;
        end
        FN_APPEND: begin
          if (facet_count >= MAX_FACETS_DEFAULT) begin
            ans.status = 1'b1;
          end else begin
            ex = push_div400(xs - xe);
            ey = push_div400(ys - ye);
            f.px = ext_t'(xs + ex);
            f.py = ext_t'(ys + ey);
            f.qx = ext_t'(xe - ex);
            f.qy = ext_t'(ye - ey);
            facets[facet_count] = f;
            facet_count++;
          end
        end
        FN_QUERY: begin
          ans.visible = 1'b1;
          for (int i = 0; i < facet_count; i++) begin
            if (facet_blocks(xs, ys, xe, ye, facets[i])) begin
              ans.visible = 1'b0;
              ans.blocking_index = i[INDEX_BITS-1:0];
              break;
            end
          end
        end
        default: ;
      endcase
      ans.facet_total = facet_count[TOTAL_BITS-1:0];
      pending_answers.push_back(ans);
    endfunction

    task report(string what);
      error_count++;
      if (error_count <= 100) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task check_answer(out_item_t got);
      out_item_t want;
      if (pending_answers.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      want = pending_answers.pop_front();
      if (got.visible !== want.visible)
        report($sformatf("visible got %b want %b", got.visible, want.visible));
      if (got.blocking_index !== want.blocking_index)
        report($sformatf("blocking_index got %0d want %0d",
                         got.blocking_index, want.blocking_index));
      if (got.status !== want.status)
        report($sformatf("status got %b want %b", got.status, want.status));
      if (got.facet_total !== want.facet_total)
        report($sformatf("facet_total got %0d want %0d",
                         got.facet_total, want.facet_total));
    endtask

    function int outstanding();
      return pending_answers.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  item;
  logic      done;
  out_item_t result;

  facet_scoreboard sb;
  int              items_sent;
  int              burst_left;

  segment_visibility_against_facets u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_answer(result);
  end

  function automatic in_item_t mk(logic [1:0] f, coord_t xs, coord_t ys, coord_t xe,
                                  coord_t ye);
    in_item_t r;
    r.func    = f;
    r.x_start = xs;
    r.y_start = ys;
    r.x_end   = xe;
    r.y_end   = ye;
    return r;
  endfunction

  // span 0 means the whole coordinate range
  function automatic coord_t pick_coord(int span);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return C_MAX;
    if (r == 1) return C_MIN;
    if (span <= 0) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 2 * span - 1)) - span);
  endfunction

  function automatic coord_t clip(longint v);
    if (v > longint'(C_MAX)) return C_MAX;
    if (v < longint'(C_MIN)) return C_MIN;
    return coord_t'(v);
  endfunction

  function automatic in_item_t rand_item(logic [1:0] f, int span);
    return mk(f, pick_coord(span), pick_coord(span), pick_coord(span), pick_coord(span));
  endfunction

  // many queries are aimed at stored facet endpoints so touching cases come up
  function automatic in_item_t make_query(int span);
    facet_t f;
    coord_t px, py, qx, qy;
    int     mode;
    mode = $urandom_range(0, 9);
    if (sb.facet_count == 0 || mode < 5) return rand_item(FN_QUERY, span);
    f  = sb.facets[$urandom_range(0, sb.facet_count - 1)];
    px = clip($signed(f.px));
    py = clip($signed(f.py));
    qx = clip($signed(f.qx));
    qy = clip($signed(f.qy));
    case (mode)
      5, 6:    return mk(FN_QUERY, px, py, pick_coord(span), pick_coord(span));
      7:       return mk(FN_QUERY, px, py, qx, qy);
      8:       return mk(FN_QUERY, pick_coord(span), pick_coord(span), qx, qy);
      default: return mk(FN_QUERY, clip((longint'(px) + qx) / 2),
                         clip((longint'(py) + qy) / 2), pick_coord(span), pick_coord(span));
    endcase
  endfunction

  task automatic issue(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    if (it.func != FN_UNUSED) items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  initial begin
    int span;
    int n_app;
    int n_q;
    sb = new();
    items_sent = 0;
    burst_left = 0;
    start <= 1'b0;
    item  <= '0;
    rst   <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, touching, degenerate, extremes, unused code
    issue(mk(FN_QUERY, 0, 0, 4096, 4096));
    issue(mk(FN_UNUSED, C_MAX, C_MIN, C_MAX, C_MIN));
    issue(mk(FN_APPEND, 0, -4096, 0, 4096));
    issue(mk(FN_QUERY, -4096, 0, 4096, 0));
    issue(mk(FN_QUERY, -4096, 4116, 4096, 4116));
    issue(mk(FN_QUERY, -4096, 4117, 4096, 4117));
    issue(mk(FN_QUERY, 4096, -100, 4096, 100));
    issue(mk(FN_QUERY, 0, 0, 0, 0));
    issue(mk(FN_QUERY, 5, 5, 5, 5));
    issue(mk(FN_QUERY, 0, -8000, 0, 8000));
    issue(mk(FN_APPEND, 100, 100, 100, 100));
    issue(mk(FN_QUERY, 0, 0, 200, 200));
    issue(mk(FN_APPEND, C_MIN, C_MIN, C_MAX, C_MAX));
    issue(mk(FN_QUERY, C_MIN, C_MAX, C_MAX, C_MIN));
    issue(mk(FN_QUERY, C_MAX, C_MAX, C_MAX, C_MAX));
    issue(mk(FN_APPEND, C_MAX, C_MIN, C_MIN, C_MAX));
    issue(mk(FN_QUERY, coord_t'('1), coord_t'('1), 0, 0));
    issue(mk(FN_UNUSED, 0, 0, 0, 0));
    issue(mk(FN_CLEAR, C_MAX, C_MAX, C_MIN, C_MIN));
    issue(mk(FN_QUERY, C_MIN, C_MIN, C_MAX, C_MAX));
    drain();

    // fill past capacity so appends get rejected
    issue(mk(FN_CLEAR, 0, 0, 0, 0));
    repeat (MAX_FACETS_DEFAULT + 3) issue(rand_item(FN_APPEND, 1024));
    repeat (4) issue(make_query(1024));
    drain();

    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0) issue(rand_item(FN_UNUSED, 0));
          else issue(rand_item(2'($urandom_range(0, 3)), 0));
        end
      end else begin
        if ($urandom_range(0, 3) != 0) issue(rand_item(FN_CLEAR, 0));
        case ($urandom_range(0, 3))
          0:       span = 16;
          1:       span = 1024;
          2:       span = 65536;
          default: span = 0;
        endcase
        n_app = $urandom_range(0, 19);
        if (n_app == 0) n_app = $urandom_range(60, 70);
        else if (n_app < 4) n_app = $urandom_range(13, 40);
        else n_app = $urandom_range(1, 12);
        repeat (n_app) issue(rand_item(FN_APPEND, span));
        n_q = $urandom_range(2, 8);
        repeat (n_q) begin
          if ($urandom_range(0, 5) == 0) issue(rand_item(FN_APPEND, span));
          else issue(make_query(span));
        end
      end
      if ($urandom_range(0, 5) == 0) drain();
    end

    drain();
    repeat (80) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("segment_visibility_against_facets verification clean");
    end else begin
      $display("segment_visibility_against_facets verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("segment_visibility_against_facets verification failed");
    $finish;
  end

endmodule
